// ----- design/taie_pkg.sv -----
// taie_pkg: shared types and constants for the toy ALU instruction executor
// no dependencies; used by the interfaces, the ALU and the top level

package taie_pkg;

   // data path and register file geometry
   localparam int DATA_W    = 32;
   localparam int REG_COUNT = 32;
   localparam int REG_IDX_W = 5;
   localparam int SHAMT_W   = 5;
   localparam int STATUS_W  = 2;

   // instruction word field positions
   localparam int OPC_MSB  = 31;
   localparam int OPC_LSB  = 26;
   localparam int DST_MSB  = 25;
   localparam int DST_LSB  = 21;
   localparam int SRC1_MSB = 20;
   localparam int SRC1_LSB = 16;
   localparam int SRC2_MSB = 15;
   localparam int SRC2_LSB = 11;
   localparam int SH_MSB   = 10;
   localparam int SH_LSB   = 6;

   // last step of the 32-step iterative operations
   localparam logic [SHAMT_W-1:0] LAST_STEP = SHAMT_W'(DATA_W - 1);

   typedef enum logic [OPC_MSB-OPC_LSB:0] {
      OP_ADD = 6'd1,
      OP_SUB = 6'd2,
      OP_MUL = 6'd3,
      OP_DIV = 6'd4,
      OP_SHL = 6'd5,
      OP_SRA = 6'd6,
      OP_AND = 6'd7,
      OP_OR  = 6'd8,
      OP_XOR = 6'd9
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_BAD_OP   = 2'd1,
      ST_DIV_ZERO = 2'd2
   } status_type;

   // top level sequencer
   typedef enum logic [2:0] {
      S_IDLE,
      S_READ_A,
      S_READ_B,
      S_DECODE,
      S_RUN,
      S_FINISH
   } seq_state_type;

   // ALU internal phase
   typedef enum logic [1:0] {
      A_IDLE,
      A_MUL,
      A_DIV,
      A_FIX
   } alu_state_type;

   // control from the sequencer to the ALU
   typedef struct packed {
      logic       start;
      opcode_type op;
   } alu_req_type;

endpackage

// ----- design/taie_if.sv -----
// taie_if: valid/ready channel interfaces for commands and results
// depends on taie_pkg for the field widths

interface taie_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   command;
   logic [taie_pkg::DATA_W-1:0]            instr_word;
   logic [taie_pkg::REG_IDX_W-1:0]         load_index;
   logic signed [taie_pkg::DATA_W-1:0]     load_value;

   modport source (output valid, command, instr_word, load_index, load_value,
                   input ready);
   modport sink   (input valid, command, instr_word, load_index, load_value,
                   output ready);
endinterface

interface taie_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [taie_pkg::REG_IDX_W-1:0]         dest_reg;
   logic signed [taie_pkg::DATA_W-1:0]     operand_a;
   logic signed [taie_pkg::DATA_W-1:0]     operand_b;
   logic signed [taie_pkg::DATA_W-1:0]     result_value;
   logic [taie_pkg::STATUS_W-1:0]          status;

   modport source (output valid, dest_reg, operand_a, operand_b, result_value, status,
                   input ready);
   modport sink   (input valid, dest_reg, operand_a, operand_b, result_value, status,
                   output ready);
endinterface

// ----- design/taie_ram.sv -----
// taie_ram: generic single write port, single read port RAM with registered read
// no dependencies

module taie_ram #(
   parameter int  WIDTH  = 32,
   parameter int  DEPTH  = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/taie_alu.sv -----
// taie_alu: shared ALU with one adder, iterative shift-add multiply and restoring divide
// depends on taie_pkg for opcodes, phases and the request struct

module taie_alu (
   input  logic                          clock,
   input  logic                          reset,
   input  taie_pkg::alu_req_type         alu_req,
   input  logic [taie_pkg::DATA_W-1:0]   opnd_a,
   input  logic [taie_pkg::DATA_W-1:0]   opnd_b,
   input  logic [taie_pkg::SHAMT_W-1:0]  shamt,
   output logic                          done,
   output logic [taie_pkg::DATA_W-1:0]   result
);

   localparam int W = taie_pkg::DATA_W;

   taie_pkg::alu_state_type      phase_ff, phase_in;
   logic                         done_ff, done_in;
   logic [taie_pkg::SHAMT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]                 acc_ff;
   logic [W-1:0]                 x_ff;
   logic [W-1:0]                 y_ff;
   logic                         neg_ff;

   logic [W:0]   add_x;
   logic [W:0]   add_y;
   logic         add_inv;
   logic [W+1:0] add_sum;
   logic         div_fit;
   logic [W-1:0] quick_res;
   logic [W-1:0] abs_a;
   logic [W-1:0] abs_b;

   // operand selection for the shared adder
   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_inv = 1'b0;
      if (alu_req.start) begin
         add_x   = {1'b0, opnd_a};
         add_y   = {1'b0, opnd_b};
         add_inv = (alu_req.op == taie_pkg::OP_SUB);
      end else begin
         unique case (phase_ff)
            taie_pkg::A_MUL: begin
               add_x = {1'b0, acc_ff};
               add_y = {1'b0, (y_ff[0] ? x_ff : '0)};
            end
            taie_pkg::A_DIV: begin
               add_x   = {acc_ff, y_ff[W-1]};
               add_y   = {1'b0, x_ff};
               add_inv = 1'b1;
            end
            taie_pkg::A_FIX: begin
               add_y   = {1'b0, y_ff};
               add_inv = neg_ff;
            end
            taie_pkg::A_IDLE: begin
            end
            default: begin
            end
         endcase
      end
   end

   // shared adder, top bit is the borrow for subtraction
   assign add_sum = {1'b0, add_x} + ({1'b0, add_y} ^ {(W+2){add_inv}})
                    + (W+2)'(add_inv);
   assign div_fit = ~add_sum[W+1];

   // magnitudes for the divider
   assign abs_a = opnd_a[W-1] ? (W'(0) - opnd_a) : opnd_a;
   assign abs_b = opnd_b[W-1] ? (W'(0) - opnd_b) : opnd_b;

   // operations computed directly from the operands at start
   always_comb begin
      unique case (alu_req.op)
         taie_pkg::OP_ADD,
         taie_pkg::OP_SUB: quick_res = add_sum[W-1:0];
         taie_pkg::OP_SHL: quick_res = opnd_a << shamt;
         taie_pkg::OP_SRA: quick_res = W'($signed(opnd_a) >>> shamt);
         taie_pkg::OP_AND: quick_res = opnd_a & opnd_b;
         taie_pkg::OP_OR:  quick_res = opnd_a | opnd_b;
         taie_pkg::OP_XOR: quick_res = opnd_a ^ opnd_b;
         default:          quick_res = '0;
      endcase
   end

   // phase register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= taie_pkg::A_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   // phase sequencing and step count
   always_comb begin
      phase_in = phase_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      if (alu_req.start) begin
         cnt_in = '0;
         if (alu_req.op == taie_pkg::OP_MUL) begin
            phase_in = taie_pkg::A_MUL;
         end else if (alu_req.op == taie_pkg::OP_DIV) begin
            phase_in = taie_pkg::A_DIV;
         end else begin
            done_in = 1'b1;
         end
      end else begin
         unique case (phase_ff)
            taie_pkg::A_MUL: begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == taie_pkg::LAST_STEP) begin
                  phase_in = taie_pkg::A_IDLE;
                  done_in  = 1'b1;
               end
            end
            taie_pkg::A_DIV: begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == taie_pkg::LAST_STEP) begin
                  phase_in = taie_pkg::A_FIX;
               end
            end
            taie_pkg::A_FIX: begin
               phase_in = taie_pkg::A_IDLE;
               done_in  = 1'b1;
            end
            taie_pkg::A_IDLE: begin
            end
            default: begin
               phase_in = taie_pkg::A_IDLE;
            end
         endcase
      end
   end

   // working registers: accumulator / remainder, multiplicand / divisor,
   // multiplier / dividend-quotient
   always_ff @(posedge clock) begin
      if (alu_req.start) begin
         if (alu_req.op == taie_pkg::OP_MUL) begin
            acc_ff <= '0;
            x_ff   <= opnd_a;
            y_ff   <= opnd_b;
         end else if (alu_req.op == taie_pkg::OP_DIV) begin
            acc_ff <= '0;
            x_ff   <= abs_b;
            y_ff   <= abs_a;
            neg_ff <= opnd_a[W-1] ^ opnd_b[W-1];
         end else begin
            acc_ff <= quick_res;
         end
      end else begin
         unique case (phase_ff)
            taie_pkg::A_MUL: begin
               acc_ff <= add_sum[W-1:0];
               x_ff   <= x_ff << 1;
               y_ff   <= y_ff >> 1;
            end
            taie_pkg::A_DIV: begin
               if (div_fit) begin
                  acc_ff <= add_sum[W-1:0];
                  y_ff   <= {y_ff[W-2:0], 1'b1};
               end else begin
                  acc_ff <= {acc_ff[W-2:0], y_ff[W-1]};
                  y_ff   <= {y_ff[W-2:0], 1'b0};
               end
            end
            taie_pkg::A_FIX: begin
               acc_ff <= add_sum[W-1:0];
            end
            taie_pkg::A_IDLE: begin
            end
            default: begin
            end
         endcase
      end
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

// ----- design/toy_alu_instruction_executor_top.sv -----
// Toy ALU instruction executor: 32 signed 32-bit registers, written by load
// commands and by decoded instruction words (add, sub, mul, signed div, shift
// left, arithmetic shift right, and, or, xor). One command is worked on at a
// time and every command gives exactly one response transfer. A load goes
// straight to its response; an unknown opcode or a divide by zero ends after
// decode; the other operations run on the shared ALU, where multiply and divide
// retire one bit per cycle through its single adder. The register file is a RAM
// with one read port, so the two sources are fetched in consecutive cycles.
// A finished response waits in an output register while the next command
// is taken. Depends on taie_pkg, taie_if, taie_ram and taie_alu.

module toy_alu_instruction_executor_top (
   input  logic       clock,
   input  logic       reset,
   taie_req_if.sink   req_ch,
   taie_rsp_if.source rsp_ch
);

   localparam int W = taie_pkg::DATA_W;

   taie_pkg::seq_state_type state_ff, state_in;

   logic [W-1:0]                   word_ff;
   logic [taie_pkg::REG_IDX_W-1:0] dest_ff;
   logic [W-1:0]                   opa_ff;
   logic [W-1:0]                   opb_ff;
   logic [W-1:0]                   res_ff;
   taie_pkg::status_type           st_ff;

   logic                           out_valid_ff, out_valid_in;
   logic [taie_pkg::REG_IDX_W-1:0] out_dest_ff;
   logic [W-1:0]                   out_opa_ff;
   logic [W-1:0]                   out_opb_ff;
   logic [W-1:0]                   out_res_ff;
   taie_pkg::status_type           out_st_ff;

   logic [taie_pkg::REG_COUNT-1:0] vld_ff;

   taie_pkg::opcode_type           opcode;
   logic [taie_pkg::REG_IDX_W-1:0] src1;
   logic [taie_pkg::REG_IDX_W-1:0] src2;
   logic [taie_pkg::SHAMT_W-1:0]   shamt;
   logic                           op_known;
   logic                           op_shift;
   logic [W-1:0]                   a_val;
   logic [W-1:0]                   b_val;
   logic                           div_zero;
   logic                           take_out;
   logic                           accept;

   logic                           ram_wr_en;
   logic [taie_pkg::REG_IDX_W-1:0] ram_rd_addr;
   logic [W-1:0]                   ram_rd_data;

   taie_pkg::alu_req_type          alu_req;
   logic                           alu_done;
   logic [W-1:0]                   alu_result;

   // instruction field decode
   assign opcode = taie_pkg::opcode_type'(word_ff[taie_pkg::OPC_MSB:taie_pkg::OPC_LSB]);
   assign src1   = word_ff[taie_pkg::SRC1_MSB:taie_pkg::SRC1_LSB];
   assign src2   = word_ff[taie_pkg::SRC2_MSB:taie_pkg::SRC2_LSB];
   assign shamt  = word_ff[taie_pkg::SH_MSB:taie_pkg::SH_LSB];

   assign op_known = (opcode >= taie_pkg::OP_ADD) && (opcode <= taie_pkg::OP_XOR);
   assign op_shift = (opcode == taie_pkg::OP_SHL) || (opcode == taie_pkg::OP_SRA);

   // register read data, never-written registers read as zero
   assign a_val    = vld_ff[src1] ? ram_rd_data : '0;
   assign b_val    = vld_ff[src2] ? ram_rd_data : '0;
   assign div_zero = (opcode == taie_pkg::OP_DIV) && (b_val == '0);

   assign accept   = (state_ff == taie_pkg::S_IDLE) && req_ch.valid;
   assign take_out = (state_ff == taie_pkg::S_FINISH) && (!out_valid_ff || rsp_ch.ready);

   assign ram_wr_en   = take_out && (st_ff == taie_pkg::ST_OK);
   assign ram_rd_addr = (state_ff == taie_pkg::S_READ_A) ? src1 : src2;

   // register file storage
   taie_ram #(
      .WIDTH (W),
      .DEPTH (taie_pkg::REG_COUNT)
   ) u_regfile (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (dest_ff),
      .wr_data (res_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // shared arithmetic unit
   taie_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .opnd_a  (opa_ff),
      .opnd_b  (b_val),
      .shamt   (shamt),
      .done    (alu_done),
      .result  (alu_result)
   );

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= taie_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequencer next state and ALU start
   always_comb begin
      state_in      = state_ff;
      alu_req.start = 1'b0;
      alu_req.op    = opcode;
      unique case (state_ff)
         taie_pkg::S_IDLE: begin
            if (req_ch.valid) begin
               state_in = req_ch.command ? taie_pkg::S_READ_A : taie_pkg::S_FINISH;
            end
         end
         taie_pkg::S_READ_A: begin
            state_in = taie_pkg::S_READ_B;
         end
         taie_pkg::S_READ_B: begin
            state_in = taie_pkg::S_DECODE;
         end
         taie_pkg::S_DECODE: begin
            if (!op_known || div_zero) begin
               state_in = taie_pkg::S_FINISH;
            end else begin
               alu_req.start = 1'b1;
               state_in      = taie_pkg::S_RUN;
            end
         end
         taie_pkg::S_RUN: begin
            if (alu_done) begin
               state_in = taie_pkg::S_FINISH;
            end
         end
         taie_pkg::S_FINISH: begin
            if (take_out) begin
               state_in = taie_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = taie_pkg::S_IDLE;
         end
      endcase
   end

   // working item registers
   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= req_ch.instr_word;
         if (req_ch.command) begin
            dest_ff <= req_ch.instr_word[taie_pkg::DST_MSB:taie_pkg::DST_LSB];
         end else begin
            dest_ff <= req_ch.load_index;
            res_ff  <= req_ch.load_value;
            opa_ff  <= '0;
            opb_ff  <= '0;
            st_ff   <= taie_pkg::ST_OK;
         end
      end
      if (state_ff == taie_pkg::S_READ_B) begin
         opa_ff <= a_val;
      end
      if (state_ff == taie_pkg::S_DECODE) begin
         opb_ff <= op_shift ? W'(shamt) : b_val;
         res_ff <= '0;
         if (!op_known) begin
            st_ff <= taie_pkg::ST_BAD_OP;
         end else if (div_zero) begin
            st_ff <= taie_pkg::ST_DIV_ZERO;
         end else begin
            st_ff <= taie_pkg::ST_OK;
         end
      end
      if ((state_ff == taie_pkg::S_RUN) && alu_done) begin
         res_ff <= alu_result;
      end
   end

   // register valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ram_wr_en) begin
         vld_ff[dest_ff] <= 1'b1;
      end
   end

   // output register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (take_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (take_out) begin
         out_dest_ff <= dest_ff;
         out_opa_ff  <= opa_ff;
         out_opb_ff  <= opb_ff;
         out_res_ff  <= res_ff;
         out_st_ff   <= st_ff;
      end
   end

   assign req_ch.ready = (state_ff == taie_pkg::S_IDLE);

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.dest_reg     = out_dest_ff;
   assign rsp_ch.operand_a    = out_opa_ff;
   assign rsp_ch.operand_b    = out_opb_ff;
   assign rsp_ch.result_value = out_res_ff;
   assign rsp_ch.status       = out_st_ff;

endmodule
